[design/brsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package brsr_pkg;

    // Field widths of the request and response payloads.
    localparam int FUNC_W  = 3;
    localparam int X_W     = 7;
    localparam int Y_W     = 5;
    localparam int COLOR_W = 4;

    // Configuration register widths.
    localparam int CW_W = 8;
    localparam int CH_W = 6;
    localparam int BR_W = 2;

    // Squared distance fits in 15 bits: 127*127 + 31*31 is below 2**15.
    localparam int ROOT_W = 15;

    // Signed plotting coordinates and error terms.
    localparam int COORD_W = 10;
    localparam int ERR_W   = 12;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int DEF_MAX_WIDTH    = 128;
    localparam int DEF_MAX_HEIGHT   = 32;
    localparam int DEF_NEWTON_STEPS = 20;

    localparam logic [CW_W-1:0]    RST_WIDTH  = 8'd79;
    localparam logic [CH_W-1:0]    RST_HEIGHT = 6'd18;
    localparam logic [BR_W-1:0]    RST_BRUSH  = 2'd1;
    localparam logic [COLOR_W-1:0] RST_BG     = 4'd15;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ERR_W-1:0]   t_err;

    typedef enum logic [FUNC_W-1:0] {
        FN_STAMP  = 3'd0,
        FN_LINE   = 3'd1,
        FN_RECT   = 3'd2,
        FN_CIRCLE = 3'd3,
        FN_CLEAR  = 3'd4,
        FN_READ   = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_BRUSH  = 2'd2,
        REG_BG     = 2'd3
    } t_reg;

endpackage

`default_nettype wire

[design/brsr_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface brsr_req_if import brsr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [X_W-1:0]     start_x;
    logic [Y_W-1:0]     start_y;
    logic [X_W-1:0]     end_x;
    logic [Y_W-1:0]     end_y;
    logic [COLOR_W-1:0] color;

    modport source (output valid, func, start_x, start_y, end_x, end_y, color,
                    input ready);
    modport sink   (input valid, func, start_x, start_y, end_x, end_y, color,
                    output ready);
endinterface

interface brsr_rsp_if import brsr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] cell_value;
    logic               was_read;

    modport source (output valid, cell_value, was_read, input ready);
    modport sink   (input valid, cell_value, was_read, output ready);
endinterface

`default_nettype wire

[design/brsr_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

// Newton integer square root; each step runs a restoring divider one
// quotient bit per cycle and then averages.
module brsr_sqrt import brsr_pkg::*; #(
    parameter int NEWTON_STEPS = DEF_NEWTON_STEPS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [ROOT_W-1:0] i_value,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);

    localparam int SC_W = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS) : 1;
    localparam int BI_W = $clog2(ROOT_W);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_AVG} t_state;

    t_state            r_state;
    logic              r_done;
    logic [ROOT_W-1:0] r_v;
    logic [ROOT_W-1:0] r_r;
    logic [ROOT_W-1:0] r_q;
    logic [ROOT_W-1:0] r_rem;
    logic [BI_W-1:0]   r_bit;
    logic [SC_W-1:0]   r_step;

    logic [ROOT_W:0]   rem_sh;
    logic [ROOT_W:0]   rem_diff;
    logic              rem_ge;
    logic [ROOT_W:0]   avg_sum;

    always_comb begin
        rem_sh   = {r_rem, r_v[r_bit]};
        rem_ge   = rem_sh >= {1'b0, r_r};
        rem_diff = rem_sh - {1'b0, r_r};
        avg_sum  = {1'b0, r_r} + {1'b0, r_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_v    <= i_value;
                        r_r    <= i_value;
                        r_step <= '0;
                        r_rem  <= '0;
                        r_q    <= '0;
                        r_bit  <= BI_W'(ROOT_W - 1);
                        if (i_value == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= rem_ge ? rem_diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
                    r_q   <= {r_q[ROOT_W-2:0], rem_ge};
                    if (r_bit == '0) begin
                        r_state <= S_AVG;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_AVG: begin
                    r_r <= avg_sum[ROOT_W:1];
                    if (r_step == SC_W'(NEWTON_STEPS - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_bit   <= BI_W'(ROOT_W - 1);
                        r_state <= S_DIV;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_r;

endmodule

`default_nettype wire

[design/brsr_canvas.sv]
`timescale 1ns / 1ps
`default_nettype none

// Canvas store: one write port and one registered read port.
module brsr_canvas import brsr_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [COLOR_W-1:0] i_wdata,
    input  wire logic [AW-1:0]      i_raddr,
    output logic [COLOR_W-1:0]      o_rdata
);

    logic [COLOR_W-1:0] r_mem [DEPTH];
    logic [COLOR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/brush_shape_rasterizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Handshake      Payload
// i_req      in   valid / ready  func, start_x, start_y, end_x, end_y, color
// o_rsp      out  valid / ready  cell_value, was_read
// APB        in   psel/penable   paddr, pwdata, prdata (pready always high)
//
// One request is taken at a time; ready is high only in the idle state.
// A stamp paints one b by b brush square, where b is the brush size; a shape
// paints one at each plotted point, cell by cell through the single canvas
// write port. A circle first takes its radius from the square root unit,
// NEWTON_STEPS steps of 15 quotient bits and one averaging step each.
// Clear and the sweep after reset write one cell a cycle over all
// MAX_WIDTH*MAX_HEIGHT cells (4096 by default); no request is taken during
// the sweep. A read registers the canvas output and then the cell value.
// A result is held until the response channel takes it.
module brush_shape_rasterizer import brsr_pkg::*; #(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int NEWTON_STEPS = DEF_NEWTON_STEPS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    brsr_req_if.sink                i_req,
    brsr_rsp_if.source              o_rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_ROOT, S_ROOT_WAIT, S_PAINT, S_READ, S_READ_DATA, S_DONE
    } t_state;

    // ---------------------------------------------------------------------
    // Config registers. Writes must come while idle; the block does not check.
    // ---------------------------------------------------------------------
    logic [CW_W-1:0]    r_cw;
    logic [CH_W-1:0]    r_ch;
    logic [BR_W-1:0]    r_brush;
    logic [COLOR_W-1:0] r_bg;
    logic               cfg_wr;
    t_reg               cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = t_reg'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw    <= RST_WIDTH;
            r_ch    <= RST_HEIGHT;
            r_brush <= RST_BRUSH;
            r_bg    <= RST_BG;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_WIDTH:  r_cw    <= pwdata[CW_W-1:0];
                REG_HEIGHT: r_ch    <= pwdata[CH_W-1:0];
                REG_BRUSH:  r_brush <= pwdata[BR_W-1:0];
                REG_BG:     r_bg    <= pwdata[COLOR_W-1:0];
                default:    r_cw    <= r_cw;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_WIDTH:  prdata = PDATA_W'(r_cw);
            REG_HEIGHT: prdata = PDATA_W'(r_ch);
            REG_BRUSH:  prdata = PDATA_W'(r_brush);
            REG_BG:     prdata = PDATA_W'(r_bg);
            default:    prdata = '0;
        endcase
    end

    // Effective clip limits: a width or height above the store size acts as
    // the store size.
    logic [COORD_W-1:0] w_lim;
    logic [COORD_W-1:0] h_lim;

    assign w_lim = (int'(r_cw) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : COORD_W'(r_cw);
    assign h_lim = (int'(r_ch) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : COORD_W'(r_ch);

    function automatic logic in_area(t_coord x, t_coord y,
                                     logic [COORD_W-1:0] w, logic [COORD_W-1:0] h);
        in_area = !x[COORD_W-1] && !y[COORD_W-1]
               && ({1'b0, x[COORD_W-2:0]} < w) && ({1'b0, y[COORD_W-2:0]} < h);
    endfunction

    function automatic logic [AW-1:0] cell_addr(t_coord x, t_coord y);
        cell_addr = AW'(int'(y[COORD_W-2:0]) * MAX_WIDTH + int'(x[COORD_W-2:0]));
    endfunction

    // ---------------------------------------------------------------------
    // Sequencer state. The generator registers hold the current point of
    // the shape; their meaning depends on the command:
    //   line:   r_x/r_y walk, r_bx/r_by end point, r_err Bresenham error
    //   rect:   r_x is the running edge coordinate, r_ax..r_by the corners
    //   circle: r_ax/r_ay centre, r_x/r_y octant offsets, r_err midpoint error
    // ---------------------------------------------------------------------
    t_state             r_state;
    t_func              r_func;
    logic [COLOR_W-1:0] r_color;
    logic [COLOR_W-1:0] r_fill;
    logic               r_sweep_reply;
    logic [AW-1:0]      r_clr;
    t_coord             r_x;
    t_coord             r_y;
    t_coord             r_ax;
    t_coord             r_ay;
    t_coord             r_bx;
    t_coord             r_by;
    t_err               r_err;
    logic [X_W-1:0]     r_dx;
    logic [Y_W-1:0]     r_dy;
    logic               r_negx;
    logic               r_negy;
    logic [2:0]         r_sub;
    logic               r_phase;
    logic [BR_W-1:0]    r_bi;
    logic [BR_W-1:0]    r_bj;
    logic [COLOR_W-1:0] r_cell;
    logic               r_was_read;

    // Request decode at acceptance.
    t_coord             q_sx;
    t_coord             q_sy;
    t_coord             q_ex;
    t_coord             q_ey;
    logic               req_take;

    assign q_sx     = t_coord'(i_req.start_x);
    assign q_sy     = t_coord'(i_req.start_y);
    assign q_ex     = t_coord'(i_req.end_x);
    assign q_ey     = t_coord'(i_req.end_y);
    assign req_take = i_req.valid && i_req.ready;

    // Current point of the generator.
    t_coord pt_x;
    t_coord pt_y;

    always_comb begin
        pt_x = r_x;
        pt_y = r_y;
        unique case (r_func)
            FN_RECT: begin
                if (!r_phase) begin
                    pt_x = r_x;
                    pt_y = r_sub[0] ? r_by : r_ay;
                end else begin
                    pt_x = r_sub[0] ? r_bx : r_ax;
                    pt_y = r_x;
                end
            end
            FN_CIRCLE: begin
                unique case (r_sub)
                    3'd0: begin pt_x = r_ax + r_x; pt_y = r_ay + r_y; end
                    3'd1: begin pt_x = r_ax + r_y; pt_y = r_ay + r_x; end
                    3'd2: begin pt_x = r_ax - r_y; pt_y = r_ay + r_x; end
                    3'd3: begin pt_x = r_ax - r_x; pt_y = r_ay + r_y; end
                    3'd4: begin pt_x = r_ax - r_x; pt_y = r_ay - r_y; end
                    3'd5: begin pt_x = r_ax - r_y; pt_y = r_ay - r_x; end
                    3'd6: begin pt_x = r_ax + r_y; pt_y = r_ay - r_x; end
                    3'd7: begin pt_x = r_ax + r_x; pt_y = r_ay - r_y; end
                    default: begin pt_x = r_x; pt_y = r_y; end
                endcase
            end
            default: begin
                pt_x = r_x;
                pt_y = r_y;
            end
        endcase
    end

    // One brush cell per cycle.
    t_coord        cell_x;
    t_coord        cell_y;
    logic          cell_in;
    logic          brush_last;

    assign cell_x     = pt_x + t_coord'(r_bi);
    assign cell_y     = pt_y + t_coord'(r_bj);
    assign cell_in    = (r_brush != '0) && in_area(cell_x, cell_y, w_lim, h_lim);
    assign brush_last = (r_brush == '0)
                     || ((r_bi == r_brush - 1'b1) && (r_bj == r_brush - 1'b1));

    // Step to the next point of the shape.
    t_coord     n_x;
    t_coord     n_y;
    t_err       n_err;
    logic [2:0] n_sub;
    logic       n_phase;
    logic       gen_done;
    t_err       e2;
    logic       step_x;
    logic       step_y;
    t_coord     cy1;
    t_coord     cx1;
    t_err       ce1;
    logic       c_dec;

    always_comb begin
        n_x      = r_x;
        n_y      = r_y;
        n_err    = r_err;
        n_sub    = r_sub;
        n_phase  = r_phase;
        gen_done = 1'b0;
        e2       = r_err <<< 1;
        step_x   = e2 > -t_err'(r_dy);
        step_y   = e2 < t_err'(r_dx);
        cy1      = r_y + t_coord'(1);
        ce1      = r_err + t_err'(1) + (t_err'(cy1) <<< 1);
        c_dec    = (((ce1 - t_err'(r_x)) <<< 1) + t_err'(1)) > t_err'(0);
        cx1      = c_dec ? r_x - t_coord'(1) : r_x;
        unique case (r_func)
            FN_LINE: begin
                if ((r_x == r_bx) && (r_y == r_by)) begin
                    gen_done = 1'b1;
                end else begin
                    n_err = r_err - (step_x ? t_err'(r_dy) : t_err'(0))
                                  + (step_y ? t_err'(r_dx) : t_err'(0));
                    if (step_x) begin
                        n_x = r_negx ? r_x - t_coord'(1) : r_x + t_coord'(1);
                    end
                    if (step_y) begin
                        n_y = r_negy ? r_y - t_coord'(1) : r_y + t_coord'(1);
                    end
                end
            end
            FN_RECT: begin
                if (!r_sub[0]) begin
                    n_sub = 3'd1;
                end else begin
                    n_sub = 3'd0;
                    if (!r_phase) begin
                        if (r_x == r_bx) begin
                            n_phase = 1'b1;
                            n_x     = r_ay;
                        end else begin
                            n_x = r_x + t_coord'(1);
                        end
                    end else if (r_x == r_by) begin
                        gen_done = 1'b1;
                    end else begin
                        n_x = r_x + t_coord'(1);
                    end
                end
            end
            FN_CIRCLE: begin
                if (r_sub != 3'd7) begin
                    n_sub = r_sub + 3'd1;
                end else begin
                    n_sub = 3'd0;
                    n_y   = cy1;
                    n_x   = cx1;
                    n_err = c_dec ? ce1 + t_err'(1) - (t_err'(cx1) <<< 1) : ce1;
                    gen_done = cx1 < cy1;
                end
            end
            default: gen_done = 1'b1;
        endcase
    end

    // ---------------------------------------------------------------------
    // Square root unit for the circle radius.
    // ---------------------------------------------------------------------
    logic              root_start;
    logic [ROOT_W-1:0] root_value;
    logic              root_done;
    logic [ROOT_W-1:0] root_out;

    assign root_start = (r_state == S_ROOT);
    assign root_value = ROOT_W'(int'(r_dx) * int'(r_dx) + int'(r_dy) * int'(r_dy));

    brsr_sqrt #(
        .NEWTON_STEPS (NEWTON_STEPS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (root_value),
        .o_done  (root_done),
        .o_root  (root_out)
    );

    // ---------------------------------------------------------------------
    // Canvas store.
    // ---------------------------------------------------------------------
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [COLOR_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [COLOR_W-1:0] mem_rdata;

    assign mem_we    = (r_state == S_SWEEP) || ((r_state == S_PAINT) && cell_in);
    assign mem_waddr = (r_state == S_SWEEP) ? r_clr : cell_addr(cell_x, cell_y);
    assign mem_wdata = (r_state == S_SWEEP) ? r_fill : r_color;
    assign mem_raddr = cell_addr(r_x, r_y);

    brsr_canvas #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ---------------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Reset fills the whole store with the reset background colour.
            r_state       <= S_SWEEP;
            r_clr         <= '0;
            r_fill        <= RST_BG;
            r_sweep_reply <= 1'b0;
        end else begin
            unique case (r_state)
                S_SWEEP: begin
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_clr      <= '0;
                        r_cell     <= '0;
                        r_was_read <= 1'b0;
                        r_state    <= r_sweep_reply ? S_DONE : S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (req_take) begin
                        r_func     <= t_func'(i_req.func);
                        r_color    <= i_req.color;
                        r_bi       <= '0;
                        r_bj       <= '0;
                        r_sub      <= '0;
                        r_phase    <= 1'b0;
                        r_x        <= q_sx;
                        r_y        <= q_sy;
                        r_ax       <= q_sx;
                        r_ay       <= q_sy;
                        r_bx       <= q_ex;
                        r_by       <= q_ey;
                        r_negx     <= q_ex < q_sx;
                        r_negy     <= q_ey < q_sy;
                        r_dx       <= (q_ex < q_sx) ? i_req.start_x - i_req.end_x
                                                    : i_req.end_x - i_req.start_x;
                        r_dy       <= (q_ey < q_sy) ? i_req.start_y - i_req.end_y
                                                    : i_req.end_y - i_req.start_y;
                        r_err      <= ((q_ex < q_sx) ? t_err'(q_sx - q_ex)
                                                     : t_err'(q_ex - q_sx))
                                    - ((q_ey < q_sy) ? t_err'(q_sy - q_ey)
                                                     : t_err'(q_ey - q_sy));
                        r_cell     <= '0;
                        r_was_read <= 1'b0;
                        unique case (i_req.func)
                            FN_STAMP, FN_LINE: r_state <= S_PAINT;
                            FN_RECT: begin
                                // Corners sorted so the edges run upwards.
                                r_x     <= (q_ex < q_sx) ? q_ex : q_sx;
                                r_ax    <= (q_ex < q_sx) ? q_ex : q_sx;
                                r_bx    <= (q_ex < q_sx) ? q_sx : q_ex;
                                r_ay    <= (q_ey < q_sy) ? q_ey : q_sy;
                                r_by    <= (q_ey < q_sy) ? q_sy : q_ey;
                                r_state <= S_PAINT;
                            end
                            FN_CIRCLE: r_state <= S_ROOT;
                            FN_CLEAR: begin
                                r_fill        <= r_bg;
                                r_sweep_reply <= 1'b1;
                                r_clr         <= '0;
                                r_state       <= S_SWEEP;
                            end
                            FN_READ: r_state <= S_READ;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_ROOT: r_state <= S_ROOT_WAIT;
                S_ROOT_WAIT: begin
                    if (root_done) begin
                        r_x     <= t_coord'(root_out);
                        r_y     <= '0;
                        r_err   <= '0;
                        r_sub   <= '0;
                        r_state <= S_PAINT;
                    end
                end
                S_PAINT: begin
                    if (brush_last) begin
                        r_bi <= '0;
                        r_bj <= '0;
                        if (gen_done) begin
                            r_state <= S_DONE;
                        end else begin
                            r_x     <= n_x;
                            r_y     <= n_y;
                            r_err   <= n_err;
                            r_sub   <= n_sub;
                            r_phase <= n_phase;
                        end
                    end else if (r_bi == r_brush - 1'b1) begin
                        r_bi <= '0;
                        r_bj <= r_bj + 1'b1;
                    end else begin
                        r_bi <= r_bi + 1'b1;
                    end
                end
                S_READ: r_state <= S_READ_DATA;
                S_READ_DATA: begin
                    // A read outside the configured area answers zero.
                    r_cell     <= in_area(r_x, r_y, w_lim, h_lim) ? mem_rdata : '0;
                    r_was_read <= 1'b1;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (o_rsp.ready) begin
                        r_sweep_reply <= 1'b0;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = (r_state == S_DONE);
    assign o_rsp.cell_value = r_cell;
    assign o_rsp.was_read   = r_was_read;

`ifndef SYNTHESIS
    // The sweep after reset must hold off requests.
    a_sweep_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req.ready)
        else $error("request accepted during the reset sweep");

    // Canvas is written only by the sweep or while painting.
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_SWEEP) || (r_state == S_PAINT))
        else $error("canvas written outside sweep or paint");

    // A response that does not answer a read carries zero.
    a_zero_non_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.was_read) |-> (o_rsp.cell_value == '0))
        else $error("non-read response with non-zero value");

    // A taken response returns the block to idle in the next cycle.
    a_resp_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready) |=> i_req.ready)
        else $error("block not idle after response taken");

    // Paint writes land inside the clip rectangle.
    a_paint_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PAINT) && mem_we) |-> in_area(cell_x, cell_y, w_lim, h_lim))
        else $error("paint write outside the clip area");
`endif

endmodule

`default_nettype wire
